// ===== hdl/hhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hhfp_pkg
// Types, byte codes and character classes for the HTTP header field parser.
// ----------------------------------------------------------------------------
package hhfp_pkg;

  localparam int unsigned CntW = 16;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [CntW-1:0] MaxBytesReset = 16'd8192;
  localparam logic [CntW-1:0] CountMax      = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_SKIP  = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_NEND  = 3'd2,
    KIND_VAL   = 3'd3,
    KIND_VEND  = 3'd4,
    KIND_DONE  = 3'd5,
    KIND_BAD   = 3'd6,
    KIND_LARGE = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_NAME     = 3'd1,
    ST_VSTART   = 3'd2,
    ST_VALUE    = 3'd3,
    ST_CR_START = 3'd4,
    ST_CR_VALUE = 3'd5,
    ST_DONE     = 3'd6
  } pstate_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_BAD   = 2'd1,
    ERR_LARGE = 2'd2
  } err_t;

  typedef struct packed {
    pstate_t         state;
    logic [CntW-1:0] byte_count;
    logic [CntW-1:0] value_count;
    logic [CntW-1:0] trimmed_count;
    err_t            err;
  } ctx_t;

  typedef struct packed {
    kind_t           kind;
    logic [7:0]      data_byte;
    logic [CntW-1:0] value_length;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab);
  endfunction

  function automatic logic is_vchar(input logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E);
  endfunction

  function automatic logic is_tchar(input logic [7:0] b);
    logic alnum;
    logic punct;
    alnum = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
            ((b >= 8'h41) && (b <= 8'h5A));
    punct = (b == 8'h21) || (b == 8'h23) || (b == 8'h24) || (b == 8'h25) ||
            (b == 8'h26) || (b == 8'h27) || (b == 8'h2A) || (b == 8'h2B) ||
            (b == 8'h2D) || (b == 8'h2E) || (b == 8'h5E) || (b == 8'h5F) ||
            (b == 8'h60) || (b == 8'h7C) || (b == 8'h7E);
    return alnum || punct;
  endfunction

endpackage

// ===== hdl/hhfp_step.sv =====
// ----------------------------------------------------------------------------
// hhfp_step
// Per-byte parser logic: next context and tagged result for one header byte.
// ----------------------------------------------------------------------------
module hhfp_step (
  input  logic [7:0]              byte_in,
  input  logic [15:0]             max_bytes,
  input  hhfp_pkg::ctx_t          ctx_cur,
  output hhfp_pkg::ctx_t          ctx_nxt,
  output hhfp_pkg::result_t       res
);
  import hhfp_pkg::*;

  logic            nz;
  logic [CntW-1:0] vcount_inc;

  assign nz         = (byte_in != ChNul);
  assign vcount_inc = (ctx_cur.value_count != CountMax) ?
                      ctx_cur.value_count + 16'd1 : ctx_cur.value_count;

  always_comb begin
    ctx_nxt = ctx_cur;
    res.kind         = KIND_SKIP;
    res.data_byte    = 8'h00;
    res.value_length = '0;

    priority if (ctx_cur.err == ERR_BAD) begin
      res.kind = KIND_BAD;
    end else if (ctx_cur.err == ERR_LARGE) begin
      res.kind = KIND_LARGE;
    end else if (ctx_cur.state == ST_DONE) begin
      res.kind = KIND_DONE;
    end else if (nz && (ctx_cur.byte_count >= max_bytes)) begin
      ctx_nxt.err = ERR_LARGE;
      res.kind    = KIND_LARGE;
    end else begin
      if (nz) begin
        ctx_nxt.byte_count = ctx_cur.byte_count + 16'd1;
      end
      unique case (ctx_cur.state)
        ST_START: begin
          if (!nz || byte_in == ChLf) begin
            ctx_nxt.state = ST_DONE;
            res.kind      = KIND_DONE;
          end else if (byte_in == ChCr) begin
            ctx_nxt.state = ST_CR_START;
          end else if (is_tchar(byte_in)) begin
            ctx_nxt.state = ST_NAME;
            res.kind      = KIND_NAME;
            res.data_byte = byte_in;
          end else begin
            ctx_nxt.err = ERR_BAD;
            res.kind    = KIND_BAD;
          end
        end
        ST_NAME: begin
          // A zero byte inside a name is dropped without effect.
          if (!nz) begin
            res.kind = KIND_SKIP;
          end else if (byte_in == ChColon) begin
            ctx_nxt.state         = ST_VSTART;
            ctx_nxt.value_count   = '0;
            ctx_nxt.trimmed_count = '0;
            res.kind              = KIND_NEND;
          end else if (is_tchar(byte_in)) begin
            res.kind      = KIND_NAME;
            res.data_byte = byte_in;
          end else begin
            ctx_nxt.err = ERR_BAD;
            res.kind    = KIND_BAD;
          end
        end
        ST_VSTART, ST_VALUE: begin
          if (!nz) begin
            ctx_nxt.state    = ST_DONE;
            res.kind         = KIND_VEND;
            res.value_length = ctx_cur.trimmed_count;
          end else if (byte_in == ChLf) begin
            ctx_nxt.state    = ST_START;
            res.kind         = KIND_VEND;
            res.value_length = ctx_cur.trimmed_count;
          end else if (byte_in == ChCr) begin
            ctx_nxt.state = ST_CR_VALUE;
          end else if (ctx_cur.state == ST_VSTART) begin
            // Leading whitespace is skipped; any other byte opens the value.
            if (!is_ws(byte_in)) begin
              ctx_nxt.state         = ST_VALUE;
              ctx_nxt.value_count   = vcount_inc;
              ctx_nxt.trimmed_count = vcount_inc;
              res.kind              = KIND_VAL;
              res.data_byte         = byte_in;
            end
          end else if (is_vchar(byte_in) || is_ws(byte_in)) begin
            ctx_nxt.value_count = vcount_inc;
            if (!is_ws(byte_in)) begin
              ctx_nxt.trimmed_count = vcount_inc;
            end
            res.kind      = KIND_VAL;
            res.data_byte = byte_in;
          end else begin
            ctx_nxt.err = ERR_BAD;
            res.kind    = KIND_BAD;
          end
        end
        ST_CR_START: begin
          if (byte_in == ChLf) begin
            ctx_nxt.state = ST_DONE;
            res.kind      = KIND_DONE;
          end else begin
            ctx_nxt.err = ERR_BAD;
            res.kind    = KIND_BAD;
          end
        end
        ST_CR_VALUE: begin
          if (byte_in == ChLf) begin
            ctx_nxt.state    = ST_START;
            res.kind         = KIND_VEND;
            res.value_length = ctx_cur.trimmed_count;
          end else begin
            ctx_nxt.err = ERR_BAD;
            res.kind    = KIND_BAD;
          end
        end
        default: begin
          ctx_nxt.state = ST_DONE;
          res.kind      = KIND_DONE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/http_header_field_parser_core.sv =====
// ----------------------------------------------------------------------------
// http_header_field_parser_core
// Byte-serial HTTP header field tokenizer with one tagged result per byte.
// ----------------------------------------------------------------------------
// One header byte is taken per beat and one result beat comes back for each,
// in order. The block sustains one byte per clock while the output is not
// stalled: a byte is first held in an input register, then the parser step and
// the context update run combinationally into the result register, which
// presents the result on the port until it is taken. The input side keeps
// accepting while a result waits, as long as the result register empties or
// the input register is free. The user must write the byte limit through the
// cfg port only while no byte is in flight; the block does not enforce this.
// The limit resets to 8192. Errors stick until reset.
module http_header_field_parser_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hhfp_pkg::kind_t       out_kind,
  output logic [7:0]            out_data_byte,
  output logic [15:0]           out_value_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_max_header_bytes
);
  import hhfp_pkg::*;

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            out_valid_r;
  result_t         res_r;
  result_t         res_nxt;
  ctx_t            ctx_r;
  ctx_t            ctx_nxt;
  logic [CntW-1:0] max_bytes_r;
  logic            advance;
  logic            in_fire;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  hhfp_step u_step (
    .byte_in   (s1_byte_r),
    .max_bytes (max_bytes_r),
    .ctx_cur   (ctx_r),
    .ctx_nxt   (ctx_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_bytes_r <= MaxBytesReset;
      ctx_r.state         <= ST_START;
      ctx_r.byte_count    <= '0;
      ctx_r.value_count   <= '0;
      ctx_r.trimmed_count <= '0;
      ctx_r.err           <= ERR_NONE;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        ctx_r       <= ctx_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        max_bytes_r <= cfg_max_header_bytes;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_value_length = res_r.value_length;

endmodule

// ===== hdl/hhfp_checker.sv =====
// ----------------------------------------------------------------------------
// hhfp_checker
// Port-level assertions for the header field parser, bound to the top level.
// ----------------------------------------------------------------------------
module hhfp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input hhfp_pkg::kind_t out_kind,
  input logic [7:0]      out_data_byte,
  input logic [15:0]     out_value_length
);
  import hhfp_pkg::*;

  logic saw_bad_r;
  logic saw_large_r;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  // Remember which sticky error has been delivered so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saw_bad_r   <= 1'b0;
      saw_large_r <= 1'b0;
    end else if (out_fire) begin
      if (out_kind == KIND_BAD) begin
        saw_bad_r <= 1'b1;
      end
      if (out_kind == KIND_LARGE) begin
        saw_large_r <= 1'b1;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_data_byte) && $stable(out_value_length))
    else $error("result beat changed while stalled");

  a_sticky_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (saw_bad_r || saw_large_r) |->
    ((saw_bad_r && out_kind == KIND_BAD) || (saw_large_r && out_kind == KIND_LARGE)))
    else $error("error kind not sticky");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_NAME && out_kind != KIND_VAL |-> out_data_byte == 8'h00)
    else $error("data byte set on a beat that tags no byte");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_VEND |-> out_value_length == 16'h0000)
    else $error("value length set outside value end");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind http_header_field_parser_core hhfp_checker u_hhfp_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HTTP header field parser core. Header bytes go
// in one per beat under random sender gaps and receiver stalls. A predictor
// of the tokenizer tags each accepted byte, and every result beat is checked
// in order against those tags. The byte limit is rewritten between phases.
// Each run ends the header block in one of several ways, picked at random,
// and then checks that later bytes keep the sticky outcome.
// ----------------------------------------------------------------------------
module testbench;
  import hhfp_pkg::*;

  typedef enum int {
    END_BLANK_LINE,
    END_BARE_LF,
    END_ZERO_AT_START,
    END_ZERO_IN_VALUE,
    END_CR_AT_START_BAD,
    END_NAME_BAD,
    END_CR_IN_VALUE_BAD,
    END_FIRST_BYTE_BAD,
    END_TOO_LARGE,
    END_VALUE_BAD
  } ending_t;

  localparam int EndingKinds = 10;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte;
  logic            out_valid;
  logic            out_ready;
  kind_t           out_kind;
  logic [7:0]      out_data_byte;
  logic [15:0]     out_value_length;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [15:0]     cfg_max_header_bytes;

  // Predictor state of the tokenizer.
  pstate_t         p_state   = ST_START;
  err_t            p_err     = ERR_NONE;
  logic [15:0]     p_bytes   = '0;
  logic [15:0]     p_vcount  = '0;
  logic [15:0]     p_vtrim   = '0;
  logic [15:0]     p_limit   = MaxBytesReset;

  result_t         expected_tags[$];

  bit              offering = 1'b0;
  bit              rx_on    = 1'b0;
  bit              tx_idle  = 1'b1;
  bit              rx_idle  = 1'b1;
  int              rx_hold  = 0;
  int              sent     = 0;
  int              checked  = 0;
  int              fails    = 0;
  int              limit_writes = 0;
  string           ending_note = "an unknown path";

  http_header_field_parser_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_value_length     (out_value_length),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_header_bytes (cfg_max_header_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character classes and the tokenizer predictor
  // ---------------------------------------------------------------------------
  function automatic bit blank_char(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic bit visible_char(input logic [7:0] c);
    return (c > 8'h20) && (c < 8'h7F);
  endfunction

  function automatic bit token_char(input logic [7:0] c);
    case (c)
      // ! # $ % & ' * + - . ^ _ ` | ~
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                      (c >= "A" && c <= "Z");
    endcase
  endfunction

  function automatic void count_value_byte(input logic [7:0] c);
    if (p_vcount != CountMax) p_vcount++;
    if (!blank_char(c)) p_vtrim = p_vcount;
  endfunction

  function automatic result_t tag_byte(input logic [7:0] b);
    result_t r;
    r.kind         = KIND_SKIP;
    r.data_byte    = '0;
    r.value_length = '0;
    if (p_err == ERR_BAD) begin
      r.kind = KIND_BAD;
    end else if (p_err == ERR_LARGE) begin
      r.kind = KIND_LARGE;
    end else if (p_state == ST_DONE) begin
      r.kind = KIND_DONE;
    end else if (b != ChNul && p_bytes >= p_limit) begin
      p_err  = ERR_LARGE;
      r.kind = KIND_LARGE;
    end else begin
      if (b != ChNul) p_bytes++;
      case (p_state)
        ST_START: begin
          if (b == ChNul || b == ChLf) begin
            p_state = ST_DONE;
            r.kind  = KIND_DONE;
          end else if (b == ChCr) begin
            p_state = ST_CR_START;
          end else if (token_char(b)) begin
            p_state     = ST_NAME;
            r.kind      = KIND_NAME;
            r.data_byte = b;
          end else begin
            p_err  = ERR_BAD;
            r.kind = KIND_BAD;
          end
        end
        ST_NAME: begin
          if (b == ChNul) begin
            r.kind = KIND_SKIP;
          end else if (b == ChColon) begin
            p_state  = ST_VSTART;
            p_vcount = '0;
            p_vtrim  = '0;
            r.kind   = KIND_NEND;
          end else if (token_char(b)) begin
            r.kind      = KIND_NAME;
            r.data_byte = b;
          end else begin
            p_err  = ERR_BAD;
            r.kind = KIND_BAD;
          end
        end
        ST_VSTART, ST_VALUE: begin
          if (b == ChNul) begin
            p_state        = ST_DONE;
            r.kind         = KIND_VEND;
            r.value_length = p_vtrim;
          end else if (b == ChLf) begin
            p_state        = ST_START;
            r.kind         = KIND_VEND;
            r.value_length = p_vtrim;
          end else if (b == ChCr) begin
            p_state = ST_CR_VALUE;
          end else if (p_state == ST_VSTART) begin
            // Leading blanks are dropped; anything else opens the value.
            if (!blank_char(b)) begin
              p_state = ST_VALUE;
              count_value_byte(b);
              r.kind      = KIND_VAL;
              r.data_byte = b;
            end
          end else if (visible_char(b) || blank_char(b)) begin
            count_value_byte(b);
            r.kind      = KIND_VAL;
            r.data_byte = b;
          end else begin
            p_err  = ERR_BAD;
            r.kind = KIND_BAD;
          end
        end
        ST_CR_START: begin
          if (b == ChLf) begin
            p_state = ST_DONE;
            r.kind  = KIND_DONE;
          end else begin
            p_err  = ERR_BAD;
            r.kind = KIND_BAD;
          end
        end
        ST_CR_VALUE: begin
          if (b == ChLf) begin
            p_state        = ST_START;
            r.kind         = KIND_VEND;
            r.value_length = p_vtrim;
          end else begin
            p_err  = ERR_BAD;
            r.kind = KIND_BAD;
          end
        end
        default: begin
          p_state = ST_DONE;
          r.kind  = KIND_DONE;
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random byte pickers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!token_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] rand_text();
    if ($urandom_range(0, 3) == 0) return rand_blank();
    return 8'($urandom_range(33, 126));
  endfunction

  // Any byte that opens a value, control and high bytes included.
  function automatic logic [7:0] rand_opener();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == ChCr || c == ChLf || blank_char(c));
    return c;
  endfunction

  function automatic logic [15:0] next_limit();
    int lo;
    lo = p_bytes + 2400;
    if (lo >= 65535 || $urandom_range(0, 3) == 0) return 16'hFFFF;
    return 16'($urandom_range(lo, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake tasks
  // ---------------------------------------------------------------------------
  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      stop_offering();
      repeat (gap) @(posedge clk);
    end
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    in_byte <= b;
    expected_tags.push_back(tag_byte(b));
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the input until every expected result beat has come back.
  task automatic settle();
    stop_offering();
    do @(posedge clk); while (expected_tags.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid            <= 1'b1;
    cfg_max_header_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_limit = v;
    limit_writes++;
    @(posedge clk);
  endtask

  // One well-formed field with random content.
  task automatic send_field();
    int i;
    int shape;
    shape = $urandom_range(0, 9);
    for (i = 0; i < $urandom_range(1, 12); i++) begin
      if (i > 0 && $urandom_range(0, 19) == 0) send_byte(ChNul);
      send_byte(rand_token());
    end
    send_byte(ChColon);
    repeat ($urandom_range(0, 2)) send_byte(rand_blank());
    if (shape == 0) begin
      send_byte(ChCr);
    end else if (shape > 1) begin
      send_byte(($urandom_range(0, 4) == 0) ? rand_opener() : 8'($urandom_range(33, 126)));
      repeat ($urandom_range(0, 20)) send_byte(rand_text());
      repeat ($urandom_range(0, 3)) send_byte(rand_blank());
      if ($urandom_range(0, 1)) send_byte(ChCr);
    end
    send_byte(ChLf);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_field_edges();
    logic [7:0] seq [0:24];
    int i;
    seq = '{8'h21, ChNul, 8'h7E, ChColon, ChSpace, ChTab, 8'hFF, "a", ChSpace, "b",
            ChSpace, ChTab, ChCr, ChLf,
            "z", ChColon, ChCr, ChLf,
            "0", ChColon, ChLf,
            "Q", ChColon, 8'h01, ChLf};
    for (i = 0; i < 25; i++) send_byte(seq[i]);
    settle();
  endtask

  task automatic test_limit_register();
    write_limit(16'hFFFF);
    send_byte("H");
    send_byte("o");
    settle();
    // The count is already past one, so only zero bytes may pass now.
    write_limit(16'd1);
    repeat (3) send_byte(ChNul);
    settle();
    write_limit(next_limit());
    send_byte(ChColon);
    send_byte("k");
    send_byte(ChCr);
    send_byte(ChLf);
    settle();
  endtask

  task automatic test_random_headers();
    int phase;
    phase = $urandom_range(0, 3);
    while (sent < 1760) begin
      tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
      repeat ($urandom_range(8, 20)) send_field();
      settle();
      write_limit(next_limit());
      phase++;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_stall();
    tx_idle = 1'b0;
    rx_hold = 80;
    send_byte("S");
    send_byte(ChColon);
    repeat (40) send_byte(rand_text());
    send_byte(ChCr);
    send_byte(ChLf);
    settle();
    tx_idle = 1'b1;
  endtask

  task automatic test_header_end();
    ending_t how;
    logic [7:0] c;
    how = ending_t'($urandom_range(0, EndingKinds - 1));
    case (how)
      END_BLANK_LINE: begin
        ending_note = "a blank CRLF line";
        send_byte(ChCr);
        send_byte(ChLf);
      end
      END_BARE_LF: begin
        ending_note = "a bare LF at a field start";
        send_byte(ChLf);
      end
      END_ZERO_AT_START: begin
        ending_note = "a zero byte at a field start";
        send_byte(ChNul);
      end
      END_ZERO_IN_VALUE: begin
        ending_note = "a zero byte inside a value";
        send_byte(rand_token());
        send_byte(ChColon);
        repeat (3) send_byte(rand_text());
        send_byte(ChSpace);
        send_byte(ChNul);
      end
      END_CR_AT_START_BAD: begin
        ending_note = "a CR at a field start without LF";
        send_byte(ChCr);
        do c = 8'($urandom_range(0, 255)); while (c == ChLf);
        send_byte(c);
      end
      END_NAME_BAD: begin
        ending_note = "a bad byte inside a name";
        send_byte(rand_token());
        send_byte(rand_token());
        do c = 8'($urandom_range(1, 255)); while (token_char(c) || c == ChColon);
        send_byte(c);
      end
      END_CR_IN_VALUE_BAD: begin
        ending_note = "a CR inside a value without LF";
        send_byte(rand_token());
        send_byte(ChColon);
        send_byte(rand_opener());
        send_byte(ChCr);
        do c = 8'($urandom_range(0, 255)); while (c == ChLf);
        send_byte(c);
      end
      END_FIRST_BYTE_BAD: begin
        ending_note = "a bad first name byte";
        do c = 8'($urandom_range(1, 255)); while (token_char(c) || c == ChCr || c == ChLf);
        send_byte(c);
      end
      END_TOO_LARGE: begin
        ending_note = "the byte limit";
        settle();
        write_limit($urandom_range(0, 1) ? 16'd1 : p_bytes + 16'($urandom_range(0, 4)));
        send_byte(rand_token());
        send_byte(ChNul);
        repeat (6) send_byte(rand_token());
      end
      default: begin
        ending_note = "a bad byte inside a value";
        send_byte(rand_token());
        send_byte(ChColon);
        send_byte(rand_opener());
        do c = 8'($urandom_range(1, 255));
        while (visible_char(c) || blank_char(c) || c == ChCr || c == ChLf);
        send_byte(c);
      end
    endcase
  endtask

  task automatic test_sticky_tail();
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        if (rx_on) begin
          out_ready <= 1'b0;
          rx_on = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!rx_on) begin
        out_ready <= 1'b1;
        rx_on = 1'b1;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_beat
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result beat: kind %0d byte %02h length %0d",
                   out_kind, out_data_byte, out_value_length);
      end else begin
        want = expected_tags.pop_front();
        checked++;
        if (out_kind !== want.kind || out_data_byte !== want.data_byte ||
            out_value_length !== want.value_length) begin
          fails++;
          if (fails <= 10)
            $display("result %0d: expected kind %0d byte %02h length %0d, got %0d %02h %0d",
                     checked, want.kind, want.data_byte, want.value_length,
                     out_kind, out_data_byte, out_value_length);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_byte              = '0;
    cfg_valid            = 1'b0;
    cfg_max_header_bytes = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_edges();
    test_limit_register();
    test_random_headers();
    test_output_stall();
    test_header_end();
    test_sticky_tail();

    repeat (8) @(posedge clk);
    fails += expected_tags.size();
    $display("Sent %0d header bytes, checked %0d result beats, %0d limit settings.",
             sent, checked, limit_writes);
    $display("The header block ended on %s; later bytes kept the final outcome.", ending_note);
    if (fails == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
